// ===== rtl/rrc_pkg.sv =====
`timescale 1ns / 1ps

package rrc_pkg;

    localparam int MAX_SIDE  = 512;
    localparam int FRAC_BITS = 8;

    localparam int COL_W   = $clog2(MAX_SIDE);
    localparam int SIDE_W  = 10;
    localparam int ADDR_W  = 2 * COL_W;
    localparam int DEPTH   = MAX_SIDE * MAX_SIDE;
    localparam int COORD_W = 20;
    localparam int CW      = 22;
    localparam int CHAR_W  = 8;

    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_DRAW  = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic [1:0] STS_OK       = 2'd0;
    localparam logic [1:0] STS_BAD_RECT = 2'd1;
    localparam logic [1:0] STS_OUTSIDE  = 2'd2;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_BG     = 2'd2;

    localparam logic [7:0] KIND_OUTLINE = 8'h72;
    localparam logic [7:0] KIND_FILLED  = 8'h52;

    localparam logic signed [CW-1:0] ONE = CW'(1) <<< FRAC_BITS;

    typedef struct packed {
        logic load_item;
        logic read_issue;
        logic sweep_step;
        logic load_result;
    } rrc_cmd_t;

    typedef struct packed {
        logic needs_sweep;
        logic sweep_last;
    } rrc_sts_t;

    function automatic logic [SIDE_W-1:0] side_in_use(input logic [SIDE_W-1:0] v);
        logic [SIDE_W-1:0] r;
        if (v == '0) begin
            r = SIDE_W'(1);
        end else if (v > SIDE_W'(MAX_SIDE)) begin
            r = SIDE_W'(MAX_SIDE);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== rtl/rectangle_raster_canvas_unit.sv =====
`timescale 1ns / 1ps
// Steps: a request is taken in idle, then dispatch issues the canvas read; clear and
// valid draw then sweep the W x H canvas in use, at most one canvas write per cycle
// on the single write port. Others skip the sweep; the result loads once the output is free.
// Flow: one request at a time; the next is taken while a result waits at the output.
// Reset: synchronous, active low; size 1x1, background 32; canvas holds no value until cleared.
module rectangle_raster_canvas_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [1:0]                  cfg_index,
    input  logic [rrc_pkg::SIDE_W-1:0]  cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_action,
    input  logic [7:0]                  s_rect_kind,
    input  logic [rrc_pkg::COORD_W-1:0] s_left_x,
    input  logic [rrc_pkg::COORD_W-1:0] s_top_y,
    input  logic [rrc_pkg::COORD_W-1:0] s_rect_width,
    input  logic [rrc_pkg::COORD_W-1:0] s_rect_height,
    input  logic [rrc_pkg::CHAR_W-1:0]  s_paint_char,
    input  logic [rrc_pkg::COL_W-1:0]   s_pixel_col,
    input  logic [rrc_pkg::COL_W-1:0]   s_pixel_row,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_status,
    output logic [rrc_pkg::CHAR_W-1:0]  m_pixel_char
);
    import rrc_pkg::*;

    rrc_cmd_t cmd;
    rrc_sts_t sts;

    assign cfg_ready = 1'b1;

    rrc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    rrc_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_action      (s_action),
        .s_rect_kind   (s_rect_kind),
        .s_left_x      (s_left_x),
        .s_top_y       (s_top_y),
        .s_rect_width  (s_rect_width),
        .s_rect_height (s_rect_height),
        .s_paint_char  (s_paint_char),
        .s_pixel_col   (s_pixel_col),
        .s_pixel_row   (s_pixel_row),
        .cmd           (cmd),
        .sts           (sts),
        .m_status      (m_status),
        .m_pixel_char  (m_pixel_char)
    );

endmodule

// ===== rtl/rrc_ctrl.sv =====
`timescale 1ns / 1ps

module rrc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  rrc_pkg::rrc_sts_t sts,
    output rrc_pkg::rrc_cmd_t cmd
);
    import rrc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE     = 4'b0001,
        ST_DISPATCH = 4'b0010,
        ST_SWEEP    = 4'b0100,
        ST_DONE     = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                cmd.read_issue = 1'b1;
                state_next     = sts.needs_sweep ? ST_SWEEP : ST_DONE;
            end
            ST_SWEEP: begin
                cmd.sweep_step = 1'b1;
                if (sts.sweep_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.load_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_result) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_accept_dispatch: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_DISPATCH))
        else $error("accepted request did not reach dispatch");

    a_sweep_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWEEP && !sts.sweep_last) |=> (state_reg == ST_SWEEP))
        else $error("sweep left before last pixel");

    a_result_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && out_free) |=> m_valid_reg)
        else $error("result not presented");

endmodule

// ===== rtl/rrc_datapath.sv =====
`timescale 1ns / 1ps

module rrc_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [1:0]                  cfg_index,
    input  logic [rrc_pkg::SIDE_W-1:0]  cfg_data,
    input  logic [1:0]                  s_action,
    input  logic [7:0]                  s_rect_kind,
    input  logic [rrc_pkg::COORD_W-1:0] s_left_x,
    input  logic [rrc_pkg::COORD_W-1:0] s_top_y,
    input  logic [rrc_pkg::COORD_W-1:0] s_rect_width,
    input  logic [rrc_pkg::COORD_W-1:0] s_rect_height,
    input  logic [rrc_pkg::CHAR_W-1:0]  s_paint_char,
    input  logic [rrc_pkg::COL_W-1:0]   s_pixel_col,
    input  logic [rrc_pkg::COL_W-1:0]   s_pixel_row,
    input  rrc_pkg::rrc_cmd_t           cmd,
    output rrc_pkg::rrc_sts_t           sts,
    output logic [1:0]                  m_status,
    output logic [rrc_pkg::CHAR_W-1:0]  m_pixel_char
);
    import rrc_pkg::*;

    logic [SIDE_W-1:0] width_reg, height_reg;
    logic [CHAR_W-1:0] bg_reg;
    logic [SIDE_W-1:0] w_use, h_use;
    logic [COL_W-1:0]  w_last, h_last;

    logic [1:0]        act_reg;
    logic              bad_reg;
    logic              outline_reg;
    logic              outside_reg;
    logic [CHAR_W-1:0] paint_reg;
    logic [COL_W-1:0]  rd_col_reg, rd_row_reg;
    logic signed [CW-1:0] x_lo_reg, x_hi_reg, x_lo1_reg, x_hi1_reg;
    logic signed [CW-1:0] y_lo_reg, y_hi_reg, y_lo1_reg, y_hi1_reg;
    logic signed [CW-1:0] x0, y0, rw, rh;
    logic              bad_next;

    logic [COL_W-1:0]  col_reg, row_reg;
    logic signed [CW-1:0] px, py;
    logic              in_x, in_y, near_x, near_y, hit;
    logic              we;
    logic [CHAR_W-1:0] wdata;

    logic [CHAR_W-1:0] mem [DEPTH];
    logic [CHAR_W-1:0] rd_reg;

    logic [1:0]        status_reg;
    logic [CHAR_W-1:0] pix_reg;

    assign w_use  = side_in_use(width_reg);
    assign h_use  = side_in_use(height_reg);
    assign w_last = COL_W'(w_use - SIDE_W'(1));
    assign h_last = COL_W'(h_use - SIDE_W'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= SIDE_W'(1);
            height_reg <= SIDE_W'(1);
            bg_reg     <= CHAR_W'(32);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                CFG_BG:     bg_reg     <= cfg_data[CHAR_W-1:0];
                default: ;
            endcase
        end
    end

    assign x0 = CW'($signed(s_left_x));
    assign y0 = CW'($signed(s_top_y));
    assign rw = CW'($signed(s_rect_width));
    assign rh = CW'($signed(s_rect_height));

    assign bad_next = (s_rect_kind != KIND_OUTLINE && s_rect_kind != KIND_FILLED)
                      || s_rect_width[COORD_W-1] || (s_rect_width == '0)
                      || s_rect_height[COORD_W-1] || (s_rect_height == '0);

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            act_reg     <= s_action;
            bad_reg     <= bad_next;
            outline_reg <= (s_rect_kind == KIND_OUTLINE);
            paint_reg   <= s_paint_char;
            rd_col_reg  <= s_pixel_col;
            rd_row_reg  <= s_pixel_row;
            outside_reg <= ({1'b0, s_pixel_col} >= w_use) || ({1'b0, s_pixel_row} >= h_use);
            x_lo_reg    <= x0;
            x_hi_reg    <= x0 + rw;
            x_lo1_reg   <= x0 + ONE;
            x_hi1_reg   <= x0 + (rw - ONE);
            y_lo_reg    <= y0;
            y_hi_reg    <= y0 + rh;
            y_lo1_reg   <= y0 + ONE;
            y_hi1_reg   <= y0 + (rh - ONE);
        end
    end

    assign sts.needs_sweep = (act_reg == ACT_CLEAR) || (act_reg == ACT_DRAW && !bad_reg);
    assign sts.sweep_last  = (col_reg == w_last) && (row_reg == h_last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (cmd.load_item) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (cmd.sweep_step) begin
            if (col_reg == w_last) begin
                col_reg <= '0;
                row_reg <= row_reg + COL_W'(1);
            end else begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

    assign px = $signed({{(CW - COL_W - FRAC_BITS){1'b0}}, col_reg, {FRAC_BITS{1'b0}}});
    assign py = $signed({{(CW - COL_W - FRAC_BITS){1'b0}}, row_reg, {FRAC_BITS{1'b0}}});

    assign in_x   = (x_lo_reg <= px) && (px <= x_hi_reg);
    assign in_y   = (y_lo_reg <= py) && (py <= y_hi_reg);
    assign near_x = (px < x_lo1_reg) || (px > x_hi1_reg);
    assign near_y = (py < y_lo1_reg) || (py > y_hi1_reg);
    assign hit    = in_x && in_y && (!outline_reg || near_x || near_y);

    assign we    = cmd.sweep_step && ((act_reg == ACT_CLEAR) || hit);
    assign wdata = (act_reg == ACT_CLEAR) ? bg_reg : paint_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[{row_reg, col_reg}] <= wdata;
        end
        if (cmd.read_issue) begin
            rd_reg <= mem[{rd_row_reg, rd_col_reg}];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_result) begin
            status_reg <= STS_OK;
            pix_reg    <= '0;
            if (act_reg == ACT_DRAW && bad_reg) begin
                status_reg <= STS_BAD_RECT;
            end else if (act_reg == ACT_READ) begin
                if (outside_reg) begin
                    status_reg <= STS_OUTSIDE;
                end else begin
                    pix_reg <= rd_reg;
                end
            end
        end
    end

    assign m_status     = status_reg;
    assign m_pixel_char = pix_reg;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import rrc_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam logic [1:0] CFG_NONE   = 2'd3;
    localparam int UNIT           = 1 << FRAC_BITS;
    localparam int COORD_MIN      = -(1 << (COORD_W - 1));
    localparam int COORD_MAX      = (1 << (COORD_W - 1)) - 1;
    localparam int WATCHDOG_LIMIT = 40000;

    typedef struct packed {
        logic [1:0]         action;
        logic [7:0]         rect_kind;
        logic [COORD_W-1:0] left_x;
        logic [COORD_W-1:0] top_y;
        logic [COORD_W-1:0] rect_width;
        logic [COORD_W-1:0] rect_height;
        logic [CHAR_W-1:0]  paint_char;
        logic [COL_W-1:0]   pixel_col;
        logic [COL_W-1:0]   pixel_row;
    } canvas_req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [CHAR_W-1:0] pixel_char;
    } canvas_resp_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [1:0]          cfg_index;
    logic [SIDE_W-1:0]   cfg_data;
    logic                s_valid;
    logic                s_ready;
    logic [1:0]          s_action;
    logic [7:0]          s_rect_kind;
    logic [COORD_W-1:0]  s_left_x;
    logic [COORD_W-1:0]  s_top_y;
    logic [COORD_W-1:0]  s_rect_width;
    logic [COORD_W-1:0]  s_rect_height;
    logic [CHAR_W-1:0]   s_paint_char;
    logic [COL_W-1:0]    s_pixel_col;
    logic [COL_W-1:0]    s_pixel_row;
    logic                m_valid;
    logic                m_ready;
    logic [1:0]          m_status;
    logic [CHAR_W-1:0]   m_pixel_char;

    logic [CHAR_W-1:0]   canvas_mem [DEPTH];
    logic [SIDE_W-1:0]   width_reg  = SIDE_W'(1);
    logic [SIDE_W-1:0]   height_reg = SIDE_W'(1);
    logic [CHAR_W-1:0]   bg_reg     = 8'd32;
    canvas_resp_t        pixel_expect [$];
    int                  mismatch_count = 0;
    int                  idle_cycles = 0;
    bit                  idling = 1'b1;

    rectangle_raster_canvas_unit DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_rect_kind   (s_rect_kind),
        .s_left_x      (s_left_x),
        .s_top_y       (s_top_y),
        .s_rect_width  (s_rect_width),
        .s_rect_height (s_rect_height),
        .s_paint_char  (s_paint_char),
        .s_pixel_col   (s_pixel_col),
        .s_pixel_row   (s_pixel_row),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_pixel_char  (m_pixel_char)
    );

    always #4 aclk = ~aclk;

    function automatic int used_side(input logic [SIDE_W-1:0] v);
        if (v == '0) begin
            return 1;
        end
        if (v > MAX_SIDE) begin
            return MAX_SIDE;
        end
        return int'(v);
    endfunction

    task automatic predict_request(input canvas_req_t rq);
        canvas_resp_t rs;
        longint x0, y0, x1, y1, px, py, one;
        int w, h;
        bit in_box, hit;
        w = used_side(width_reg);
        h = used_side(height_reg);
        one = longint'(1) << FRAC_BITS;
        rs.status = STS_OK;
        rs.pixel_char = '0;
        case (rq.action)
            ACT_CLEAR: begin
                for (int r = 0; r < h; r++) begin
                    for (int c = 0; c < w; c++) begin
                        canvas_mem[r * MAX_SIDE + c] = bg_reg;
                    end
                end
            end
            ACT_DRAW: begin
                x0 = longint'($signed(rq.left_x));
                y0 = longint'($signed(rq.top_y));
                x1 = x0 + longint'($signed(rq.rect_width));
                y1 = y0 + longint'($signed(rq.rect_height));
                if ((rq.rect_kind != KIND_OUTLINE && rq.rect_kind != KIND_FILLED) ||
                    $signed(rq.rect_width) <= 0 || $signed(rq.rect_height) <= 0) begin
                    rs.status = STS_BAD_RECT;
                end else begin
                    for (int r = 0; r < h; r++) begin
                        py = longint'(r) * one;
                        for (int c = 0; c < w; c++) begin
                            px = longint'(c) * one;
                            in_box = x0 <= px && px <= x1 && y0 <= py && py <= y1;
                            hit = in_box;
                            if (in_box && rq.rect_kind == KIND_OUTLINE) begin
                                hit = (x1 - px < one) || (y1 - py < one) ||
                                      (px - x0 < one) || (py - y0 < one);
                            end
                            if (hit) begin
                                canvas_mem[r * MAX_SIDE + c] = rq.paint_char;
                            end
                        end
                    end
                end
            end
            ACT_READ: begin
                if (rq.pixel_col >= w || rq.pixel_row >= h) begin
                    rs.status = STS_OUTSIDE;
                end else begin
                    rs.pixel_char = canvas_mem[int'(rq.pixel_row) * MAX_SIDE +
                                               int'(rq.pixel_col)];
                end
            end
            default: begin
            end
        endcase
        pixel_expect.push_back(rs);
    endtask

    task automatic send_request(input canvas_req_t rq);
        if (idling && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_action      <= rq.action;
        s_rect_kind   <= rq.rect_kind;
        s_left_x      <= rq.left_x;
        s_top_y       <= rq.top_y;
        s_rect_width  <= rq.rect_width;
        s_rect_height <= rq.rect_height;
        s_paint_char  <= rq.paint_char;
        s_pixel_col   <= rq.pixel_col;
        s_pixel_row   <= rq.pixel_row;
        do @(posedge aclk); while (!s_ready);
        predict_request(rq);
    endtask

    function automatic canvas_req_t random_fields();
        canvas_req_t rq;
        rq.action      = 2'($urandom);
        rq.rect_kind   = 8'($urandom);
        rq.left_x      = COORD_W'($urandom);
        rq.top_y       = COORD_W'($urandom);
        rq.rect_width  = COORD_W'($urandom);
        rq.rect_height = COORD_W'($urandom);
        rq.paint_char  = CHAR_W'($urandom);
        rq.pixel_col   = COL_W'($urandom);
        rq.pixel_row   = COL_W'($urandom);
        return rq;
    endfunction

    task automatic send_action(input logic [1:0] action);
        canvas_req_t rq;
        rq = random_fields();
        rq.action = action;
        send_request(rq);
    endtask

    task automatic send_draw(input logic [7:0] kind, input int x, input int y,
                             input int rw, input int rh, input logic [7:0] paint);
        canvas_req_t rq;
        rq = random_fields();
        rq.action      = ACT_DRAW;
        rq.rect_kind   = kind;
        rq.left_x      = COORD_W'(x);
        rq.top_y       = COORD_W'(y);
        rq.rect_width  = COORD_W'(rw);
        rq.rect_height = COORD_W'(rh);
        rq.paint_char  = paint;
        send_request(rq);
    endtask

    task automatic send_read(input int col, input int row);
        canvas_req_t rq;
        rq = random_fields();
        rq.action    = ACT_READ;
        rq.pixel_col = COL_W'(col);
        rq.pixel_row = COL_W'(row);
        send_request(rq);
    endtask

    function automatic canvas_req_t random_request();
        canvas_req_t rq;
        int w, h, pick, x, y, rw, rh;
        w = used_side(width_reg);
        h = used_side(height_reg);
        rq = random_fields();
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            rq.action = ACT_CLEAR;
        end else if (pick < 8) begin
            rq.action = ACT_UNUSED;
        end else if (pick < 18) begin
            rq.action = ACT_DRAW;
            if (pick < 13) begin
                rq.rect_kind = $urandom_range(0, 1) ? KIND_OUTLINE : KIND_FILLED;
            end
        end else if (pick < 55) begin
            rq.action = ACT_DRAW;
            rq.rect_kind = $urandom_range(0, 1) ? KIND_OUTLINE : KIND_FILLED;
            x = int'($urandom_range(0, (w + 4) * UNIT)) - 2 * UNIT;
            y = int'($urandom_range(0, (h + 4) * UNIT)) - 2 * UNIT;
            rw = $urandom_range(0, 3) == 0 ? int'($urandom_range(1, 2 * UNIT))
                                           : int'($urandom_range(1, (w + 2) * UNIT));
            rh = $urandom_range(0, 3) == 0 ? int'($urandom_range(1, 2 * UNIT))
                                           : int'($urandom_range(1, (h + 2) * UNIT));
            if ($urandom_range(0, 2) == 0) begin
                x  = x & ~(UNIT - 1);
                y  = y & ~(UNIT - 1);
                rw = (rw + UNIT - 1) & ~(UNIT - 1);
                rh = (rh + UNIT - 1) & ~(UNIT - 1);
            end
            rq.left_x      = COORD_W'(x);
            rq.top_y       = COORD_W'(y);
            rq.rect_width  = COORD_W'(rw);
            rq.rect_height = COORD_W'(rh);
        end else if (pick < 62) begin
            rq.action = ACT_READ;
        end else begin
            rq.action    = ACT_READ;
            rq.pixel_col = COL_W'($urandom_range(0, w - 1));
            rq.pixel_row = COL_W'($urandom_range(0, h - 1));
        end
        return rq;
    endfunction

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pixel_expect.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [SIDE_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_WIDTH:  width_reg = data;
            CFG_HEIGHT: height_reg = data;
            CFG_BG:     bg_reg = data[CHAR_W-1:0];
            default: begin
            end
        endcase
    endtask

    task automatic configure_canvas(input logic [SIDE_W-1:0] w, input logic [SIDE_W-1:0] h,
                                    input logic [CHAR_W-1:0] bg);
        drain_results();
        write_register(CFG_NONE, SIDE_W'($urandom));
        write_register(CFG_WIDTH, w);
        write_register(CFG_HEIGHT, h);
        write_register(CFG_BG, {2'($urandom), bg});
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [SIDE_W-1:0] w, input logic [SIDE_W-1:0] h,
                             input int count);
        configure_canvas(w, h, CHAR_W'($urandom));
        send_action(ACT_CLEAR);
        repeat (count) send_request(random_request());
    endtask

    task automatic test_reset_defaults();
        send_action(ACT_CLEAR);
        send_read(0, 0);
        send_read(1, 0);
        send_draw(KIND_FILLED, -UNIT / 2, -UNIT / 2, UNIT / 2, UNIT / 2, "A");
        send_read(0, 0);
        send_read(0, 1);
    endtask

    task automatic test_directed();
        configure_canvas(SIDE_W'(8), SIDE_W'(6), ".");
        send_action(ACT_CLEAR);
        send_draw(KIND_FILLED, UNIT, UNIT, 3 * UNIT, 2 * UNIT, "#");
        send_draw(KIND_OUTLINE, 0, 0, 7 * UNIT, 5 * UNIT, "+");
        send_draw(KIND_OUTLINE, UNIT / 2, UNIT / 2, 6 * UNIT, 4 * UNIT + UNIT / 4, "o");
        send_draw(KIND_OUTLINE, 5 * UNIT, 0, UNIT / 2, 5 * UNIT, "|");
        send_draw(KIND_FILLED, -2 * UNIT, -UNIT - UNIT / 2, 4 * UNIT, 3 * UNIT, "c");
        send_draw(KIND_FILLED, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, "z");
        send_draw(KIND_OUTLINE, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, "z");
        send_draw(8'h78, UNIT, UNIT, UNIT, UNIT, "x");
        send_draw(KIND_FILLED, UNIT, UNIT, 0, UNIT, "x");
        send_draw(KIND_OUTLINE, UNIT, UNIT, 2 * UNIT, -UNIT, "x");
        send_action(ACT_UNUSED);
        send_read(0, 0);
        send_read(7, 5);
        send_read(1, 1);
        send_read(3, 2);
        send_read(5, 3);
        send_read(2, 4);
        send_read(6, 1);
        send_read(8, 0);
        send_read(0, 6);
        send_read(511, 511);
    endtask

    task automatic test_size_extremes();
        run_phase(SIDE_W'(0), SIDE_W'(1023), 6);
        send_read(0, 511);
        send_read(1, 0);
        run_phase(SIDE_W'(1023), SIDE_W'(0), 6);
        send_read(511, 0);
        send_read(0, 1);
        run_phase(SIDE_W'(512), SIDE_W'(2), 6);
        send_read(511, 1);
    endtask

    task automatic test_random_phases();
        repeat (3) begin
            run_phase(SIDE_W'($urandom_range(1, 24)), SIDE_W'($urandom_range(1, 24)), 10);
        end
    endtask

    task automatic test_steady_flow();
        idling = 1'b0;
        run_phase(SIDE_W'(16), SIDE_W'(16), 16);
    endtask

    initial begin : sink_stalls
        int n;
        m_ready <= 1'b0;
        repeat (8) @(posedge aclk);
        forever begin
            if (idling && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                n = $urandom_range(1, 19);
            end else begin
                m_ready <= 1'b1;
                n = $urandom_range(1, 40);
            end
            repeat (n) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin : check_results
        canvas_resp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pixel_expect.size() == 0) begin
                $display("%0t: unexpected result, expected none, got status %0d pixel %02h",
                         $time, m_status, m_pixel_char);
                mismatch_count++;
            end else begin
                want = pixel_expect.pop_front();
                if (m_status !== want.status) begin
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, want.status, m_status);
                    mismatch_count++;
                end
                if (m_pixel_char !== want.pixel_char) begin
                    $display("%0t: pixel_char mismatch, expected %02h, got %02h",
                             $time, want.pixel_char, m_pixel_char);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        aresetn       <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        s_valid       <= 1'b0;
        s_action      <= '0;
        s_rect_kind   <= '0;
        s_left_x      <= '0;
        s_top_y       <= '0;
        s_rect_width  <= '0;
        s_rect_height <= '0;
        s_paint_char  <= '0;
        s_pixel_col   <= '0;
        s_pixel_row   <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_directed();
        test_size_extremes();
        test_random_phases();
        test_steady_flow();

        drain_results();
        repeat (used_side(width_reg) * used_side(height_reg) + 16) @(posedge aclk);
        if (mismatch_count == 0 && pixel_expect.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
